FILE: sv/lkvc_pkg.sv
package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic OPCODE_GET = 1'b0;
   localparam logic OPCODE_PUT = 1'b1;

   localparam logic [VAL_W-1:0] MISS_VALUE = '1;   // -1
   localparam logic [VAL_W-1:0] PUT_VALUE  = '0;
   localparam logic [CAP_W-1:0] CAP_RESET  = 5'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PROMOTE,   // move the hit entry to the head, shift younger ones down
      CELL_INSERT     // new pair at the head, drop entries past the keep limit
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic                   probe;       // latch key compare against head_key
      logic [KEY_W-1:0]       head_key;
      logic [VAL_W-1:0]       head_value;
   } cell_ctrl_type;

endpackage

FILE: sv/lru_key_value_cache.sv
// Each request is taken, compared in every cell, then the cell chain is shifted and the
// result register loaded; the shift waits while an unaccepted result is held. A new
// request is taken only once this is done; the result register lets it in while it waits.
// Reset: synchronous, clears every entry's valid bit, the fill count, the
// pending result, and sets capacity_in_use to 2.
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*KEY_W-1:0]    req_tdata,    // lookup_key[31:0], write_value[63:32]
   input  logic                  req_tuser,    // opcode
   // response
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VAL_W-1:0]      rsp_tdata,    // read_value[31:0]
   output logic                  rsp_tuser,    // hit
   // capacity_in_use
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_data
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CMP_W-1:0] MAX_CAP = CMP_W'(MAX_ENTRIES);

   state_type state_ff, state_in;

   logic [CAP_W-1:0] capacity_ff;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [KEY_W-1:0] req_key_ff;
   logic [VAL_W-1:0] req_value_ff;
   logic             req_op_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;

   cell_ctrl_type    ctrl;
   logic [IDX_W-1:0] limit;
   logic             upd_go;

   logic [KEY_W-1:0] cell_key   [MAX_ENTRIES];
   logic [VAL_W-1:0] cell_value [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_valid;
   logic [MAX_ENTRIES-1:0] cell_match;

   logic             hit_any;
   logic [IDX_W-1:0] hit_pos;
   logic [VAL_W-1:0] hit_value;
   logic [CMP_W-1:0] cap_wide;
   logic [CNT_W-1:0] cap_eff;
   logic [CNT_W-1:0] keep;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign upd_go     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);

   // at most one cell matches: keys in the chain are unique
   always_comb begin
      hit_any   = 1'b0;
      hit_pos   = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (cell_match[i]) begin
            hit_any   = 1'b1;
            hit_pos   = hit_pos | IDX_W'(i);
            hit_value = hit_value | cell_value[i];
         end
      end
   end

   // capacity clamped to 1 .. MAX_ENTRIES
   always_comb begin
      cap_wide = CMP_W'(capacity_ff);
      if (cap_wide == '0) begin
         cap_wide = CMP_W'(1);
      end else if (cap_wide > MAX_CAP) begin
         cap_wide = MAX_CAP;
      end
      cap_eff = cap_wide[CNT_W-1:0];
      keep    = (occ_ff >= cap_eff) ? (cap_eff - CNT_W'(1)) : occ_ff;
   end

   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_data_in     = rsp_data_ff;
      ctrl.op         = CELL_HOLD;
      ctrl.probe      = 1'b0;
      ctrl.head_key   = req_key_ff;
      ctrl.head_value = req_value_ff;
      limit           = hit_pos;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            ctrl.probe = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_any;
               if (req_op_ff == OPCODE_GET) begin
                  if (hit_any) begin
                     ctrl.op         = CELL_PROMOTE;
                     ctrl.head_value = hit_value;
                     rsp_data_in     = hit_value;
                  end else begin
                     rsp_data_in = MISS_VALUE;
                  end
               end else begin
                  rsp_data_in = PUT_VALUE;
                  if (hit_any) begin
                     ctrl.op = CELL_PROMOTE;
                  end else begin
                     ctrl.op = CELL_INSERT;
                     limit   = IDX_W'(keep);
                     occ_in  = keep + CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
      if (req_tvalid && req_tready) begin
         req_key_ff   <= req_tdata[KEY_W-1:0];
         req_value_ff <= req_tdata[2*KEY_W-1:KEY_W];
         req_op_ff    <= req_tuser;
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic [VAL_W-1:0] prev_value;
      logic             prev_valid;

      if (g == 0) begin : g_head
         assign prev_key   = ctrl.head_key;
         assign prev_value = ctrl.head_value;
         assign prev_valid = 1'b1;
      end else begin : g_tail
         assign prev_key   = cell_key[g-1];
         assign prev_value = cell_value[g-1];
         assign prev_valid = cell_valid[g-1];
      end

      lkvc_cell #(
         .IDX_W (IDX_W),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .limit      (limit),
         .prev_key   (prev_key),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .key        (cell_key[g]),
         .value      (cell_value[g]),
         .valid      (cell_valid[g]),
         .match      (cell_match[g])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

   // keys are unique in the chain, so a lookup hits one cell at most
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(cell_match))
      else $error("more than one cell matched the key");

   // the fill count tracks the valid cells
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(occ_ff))
      else $error("fill count disagrees with valid cells");

   // a result beat only appears out of the update step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_UPDATE)
      else $error("response raised outside the update step");

   // the fill count never exceeds the chain
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= MAX_ENTRIES)
      else $error("fill count beyond chain length");

endmodule

FILE: sv/lkvc_cell.sv
module lkvc_cell
   import lkvc_pkg::*;
#(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [IDX_W-1:0]   limit,
   input  logic [KEY_W-1:0]   prev_key,
   input  logic [VAL_W-1:0]   prev_value,
   input  logic               prev_valid,
   output logic [KEY_W-1:0]   key,
   output logic [VAL_W-1:0]   value,
   output logic               valid,
   output logic               match
);

   localparam bit              FIRST    = (INDEX == 0);
   localparam logic [IDX_W:0]  CELL_IDX = (IDX_W+1)'(INDEX);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             valid_ff, valid_in;
   logic             match_ff, match_in;
   logic             in_range;

   // cell takes its neighbor's entry when it sits between the head and the limit
   assign in_range = !FIRST && ({1'b0, limit} >= CELL_IDX);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_PROMOTE: begin
            if (FIRST) begin
               key_in   = ctrl.head_key;
               value_in = ctrl.head_value;
               valid_in = 1'b1;
            end else if (in_range) begin
               key_in   = prev_key;
               value_in = prev_value;
               valid_in = prev_valid;
            end
         end
         CELL_INSERT: begin
            if (FIRST) begin
               key_in   = ctrl.head_key;
               value_in = ctrl.head_value;
               valid_in = 1'b1;
            end else if (in_range) begin
               key_in   = prev_key;
               value_in = prev_value;
               valid_in = 1'b1;
            end else begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      match_in = ctrl.probe ? (valid_ff && (key_ff == ctrl.head_key)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule
